// ----- hw/rtl/pcg_pkg.sv -----
// ----------------------------------------------------------------------------
// pcg_pkg
// Shared types, constants and helper functions of the pcg32 generator core.
// ----------------------------------------------------------------------------
`default_nettype none

package pcg_pkg;

  localparam logic [63:0] LCG_MULT   = 64'h5851f42d4c957f2d;
  localparam logic [63:0] FMIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int          FMIX_SHIFT = 33;
  localparam int          XS_SHIFT_A = 18;
  localparam int          XS_SHIFT_B = 27;
  localparam int          ROT_SHIFT  = 59;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic [1:0] {
    OP_SEED  = 2'd0,
    OP_RAW   = 2'd1,
    OP_RANGE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    K_C1  = 2'd0,
    K_C2  = 2'd1,
    K_LCG = 2'd2
  } ksel_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] seed;
    logic [31:0] lo;
    logic [31:0] span;
    logic        span_zero;
  } cmd_t;

  function automatic logic [63:0] mul_const(input ksel_t k);
    logic [63:0] c;
    case (k)
      K_C1:    c = FMIX_C1;
      K_C2:    c = FMIX_C2;
      default: c = LCG_MULT;
    endcase
    return c;
  endfunction

  // xorshift high, random rotate output stage
  function automatic logic [31:0] xsh_rr(input logic [63:0] old);
    logic [63:0] x;
    logic [31:0] xs;
    logic [4:0]  rot;
    logic [63:0] dbl;
    x   = old ^ (old >> XS_SHIFT_A);
    xs  = x[XS_SHIFT_B +: 32];
    rot = old[ROT_SHIFT +: 5];
    dbl = {xs, xs} >> rot;
    return dbl[31:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pcg32_random_generator_core.sv -----
// ----------------------------------------------------------------------------
// pcg32_random_generator_core
// PCG32 XSH-RR generator with seeding, raw and ranged draws.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  input   | in_valid / in_ready  | func, seed, range_low, range_high
//  output  | out_valid/out_ready  | raw_number, ranged_number, full_span
//
// Per beat the back sequencer runs a raw draw, a ranged draw (bit-serial
// modulo, one quotient bit per cycle), a seed (five 64-bit products, each from
// partial products of the shared 32x32 multiplier) or an unused code.
// The front takes beats into a two-entry queue while the back is busy.
// rst is synchronous; state resets to 0, increment to 1.
// A stalled output holds the back in its final step; the queue keeps filling.
// ----------------------------------------------------------------------------
`default_nettype none

module pcg32_random_generator_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         func,
  input  wire logic [31:0]        seed,
  input  wire logic signed [31:0] range_low,
  input  wire logic signed [31:0] range_high,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [31:0]             raw_number,
  output logic signed [31:0]      ranged_number,
  output logic                    full_span
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;
  pcg_pkg::cmd_t push_cmd;
  pcg_pkg::cmd_t head_cmd;

  pcg_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .seed       (seed),
    .range_low  (range_low),
    .range_high (range_high),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  pcg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (head_cmd)
  );

  pcg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (head_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .raw_number    (raw_number),
    .ranged_number (ranged_number),
    .full_span     (full_span)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/pcg_front.sv -----
// ----------------------------------------------------------------------------
// pcg_front
// Accepts input beats, decodes the operation and works out the range span.
// ----------------------------------------------------------------------------
`default_nettype none

module pcg_front (
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         func,
  input  wire logic [31:0]        seed,
  input  wire logic signed [31:0] range_low,
  input  wire logic signed [31:0] range_high,
  input  wire logic               q_full,
  output logic                    q_push,
  output pcg_pkg::cmd_t           q_cmd
);

  logic [31:0] diff;
  logic [31:0] mag;
  logic [31:0] span;

  always_comb begin
    diff = $unsigned(range_high) - $unsigned(range_low);
    // magnitude with 32-bit wrap, most negative stays 0x80000000
    mag  = diff[31] ? (32'd0 - diff) : diff;
    span = mag + 32'd1;
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.op        = pcg_pkg::op_t'(func);
    q_cmd.seed      = seed;
    q_cmd.lo        = $unsigned(range_low);
    q_cmd.span      = span;
    q_cmd.span_zero = (span == 32'd0);
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pcg_queue.sv -----
// ----------------------------------------------------------------------------
// pcg_queue
// Two-entry command queue decoupling the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pcg_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire pcg_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output pcg_pkg::cmd_t      head
);

  pcg_pkg::cmd_t                  entries [pcg_pkg::QDEPTH];
  logic [pcg_pkg::QPTR_W-1:0]     wr_ptr;
  logic [pcg_pkg::QPTR_W-1:0]     rd_ptr;
  logic [pcg_pkg::QCNT_W-1:0]     count;

  assign full      = (count == pcg_pkg::QCNT_W'(pcg_pkg::QDEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pcg_back.sv -----
// ----------------------------------------------------------------------------
// pcg_back
// Sequencer holding the generator state: shared 32x32 multiplier for the
// 64-bit products, bit-serial modulo, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcg_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire pcg_pkg::cmd_t q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [31:0]        raw_number,
  output logic signed [31:0] ranged_number,
  output logic               full_span
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_XS   = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_ADV  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_DONE = 6'b100000
  } fsm_t;

  // seeding steps through the two finalizer passes, each followed by a multiply
  localparam logic [2:0] SEQ_A1  = 3'd0;
  localparam logic [2:0] SEQ_A2  = 3'd1;
  localparam logic [2:0] SEQ_MIX = 3'd2;
  localparam logic [2:0] SEQ_B2  = 3'd3;
  localparam logic [2:0] SEQ_ADD = 3'd4;

  localparam logic [1:0] PH_LAST = 2'd3;
  localparam logic [4:0] DIV_LAST = 5'd31;

  fsm_t            fsm;
  logic [63:0]     lcg_state;
  logic [63:0]     lcg_increment;
  logic [63:0]     w;
  logic [63:0]     mop;
  logic [63:0]     acc;
  logic [63:0]     prod;
  pcg_pkg::ksel_t  ksel;
  logic [1:0]      ph;
  logic [2:0]      seq;
  pcg_pkg::op_t    op;
  logic [31:0]     lo;
  logic [31:0]     span;
  logic            span_zero;
  logic [31:0]     raw_r;
  logic [31:0]     rem;
  logic [31:0]     dq;
  logic [4:0]      cnt;
  logic [31:0]     raw_o;
  logic [31:0]     ranged_o;
  logic            full_o;

  logic [63:0]     wx;
  logic [63:0]     wx2;
  logic [63:0]     kval;
  logic [31:0]     mul_a;
  logic [31:0]     mul_b;
  logic [63:0]     prod_next;
  logic [32:0]     r2;
  logic            ge;
  logic [32:0]     r2_sub;
  logic [63:0]     sum_state;
  logic            load_out;

  always_comb begin
    wx        = w ^ (w >> pcg_pkg::FMIX_SHIFT);
    wx2       = wx ^ (wx >> pcg_pkg::FMIX_SHIFT);
    sum_state = lcg_state + wx;
    kval      = pcg_pkg::mul_const(ksel);
    // partial products: lo*lo, lo*hi, hi*lo
    case (ph)
      2'd0:    begin mul_a = mop[31:0];  mul_b = kval[31:0];  end
      2'd1:    begin mul_a = mop[31:0];  mul_b = kval[63:32]; end
      default: begin mul_a = mop[63:32]; mul_b = kval[31:0];  end
    endcase
    prod_next = mul_a * mul_b;
    r2        = {rem, dq[31]};
    ge        = (r2 >= {1'b0, span});
    r2_sub    = r2 - {1'b0, span};
  end

  assign q_pop    = (fsm == ST_IDLE) && q_valid;
  assign load_out = (fsm == ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm           <= ST_IDLE;
      lcg_state     <= 64'd0;
      lcg_increment <= 64'd1;
      out_valid     <= 1'b0;
      ph            <= '0;
      seq           <= '0;
      cnt           <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (fsm)
        ST_IDLE: begin
          if (q_valid) begin
            op        <= q_cmd.op;
            lo        <= q_cmd.lo;
            span      <= q_cmd.span;
            span_zero <= q_cmd.span_zero;
            w         <= {31'd0, q_cmd.seed, 1'b1};
            seq       <= SEQ_A1;
            ph        <= '0;
            raw_r     <= pcg_pkg::xsh_rr(lcg_state);
            mop       <= lcg_state;
            ksel      <= pcg_pkg::K_LCG;
            case (q_cmd.op)
              pcg_pkg::OP_SEED:  fsm <= ST_XS;
              pcg_pkg::OP_RAW:   fsm <= ST_MUL;
              pcg_pkg::OP_RANGE: fsm <= ST_MUL;
              default:           fsm <= ST_DONE;
            endcase
          end
        end
        ST_XS: begin
          ph  <= '0;
          fsm <= ST_MUL;
          case (seq)
            SEQ_MIX: begin
              // wx is the seed mix: set increment, first step from zero state
              lcg_increment <= {wx[62:0], 1'b1};
              lcg_state     <= {wx[62:0], 1'b1};
              mop           <= wx2;
              ksel          <= pcg_pkg::K_C1;
            end
            SEQ_ADD: begin
              lcg_state <= sum_state;
              mop       <= sum_state;
              ksel      <= pcg_pkg::K_LCG;
            end
            SEQ_A2, SEQ_B2: begin
              mop  <= wx;
              ksel <= pcg_pkg::K_C2;
            end
            default: begin
              mop  <= wx;
              ksel <= pcg_pkg::K_C1;
            end
          endcase
        end
        ST_MUL: begin
          ph   <= ph + 2'd1;
          prod <= prod_next;
          case (ph)
            2'd0:    acc <= acc;
            2'd1:    acc <= prod;
            default: acc <= {acc[63:32] + prod[31:0], acc[31:0]};
          endcase
          if (ph == PH_LAST) begin
            w <= {acc[63:32] + prod[31:0], acc[31:0]};
            if (ksel == pcg_pkg::K_LCG) begin
              fsm <= ST_ADV;
            end else begin
              seq <= seq + 3'd1;
              fsm <= ST_XS;
            end
          end
        end
        ST_ADV: begin
          lcg_state <= w + lcg_increment;
          rem       <= '0;
          dq        <= raw_r;
          cnt       <= '0;
          if (op == pcg_pkg::OP_RANGE && !span_zero) begin
            fsm <= ST_DIV;
          end else begin
            fsm <= ST_DONE;
          end
        end
        ST_DIV: begin
          rem <= ge ? r2_sub[31:0] : r2[31:0];
          dq  <= {dq[30:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == DIV_LAST) begin
            fsm <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            fsm <= ST_IDLE;
          end
        end
        default: fsm <= ST_IDLE;
      endcase
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (load_out) begin
      case (op)
        pcg_pkg::OP_RAW: begin
          raw_o    <= raw_r;
          ranged_o <= '0;
          full_o   <= 1'b0;
        end
        pcg_pkg::OP_RANGE: begin
          raw_o    <= raw_r;
          ranged_o <= span_zero ? (lo + raw_r) : (lo + rem);
          full_o   <= span_zero;
        end
        default: begin
          raw_o    <= '0;
          ranged_o <= '0;
          full_o   <= 1'b0;
        end
      endcase
    end
  end

  assign raw_number    = raw_o;
  assign ranged_number = $signed(ranged_o);
  assign full_span     = full_o;

endmodule

`default_nettype wire

// ----- hw/rtl/pcg_checker.sv -----
// ----------------------------------------------------------------------------
// pcg_checker
// Port-level checks of the generator core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pcg_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic [1:0]         func,
  input wire logic [31:0]        seed,
  input wire logic signed [31:0] range_low,
  input wire logic signed [31:0] range_high,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [31:0]        raw_number,
  input wire logic signed [31:0] ranged_number,
  input wire logic               full_span
);

  // beats taken in but not yet delivered
  logic [2:0] pending;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({in_beat, out_beat})
        2'b10:   pending <= pending + 3'd1;
        2'b01:   pending <= pending - 3'd1;
        default: pending <= pending;
      endcase
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result without an outstanding beat");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd4)
    else $error("more beats in flight than queue and stages hold");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(raw_number)
      && $stable(ranged_number) && $stable(full_span))
    else $error("stalled result changed");

endmodule

bind pcg32_random_generator_core pcg_checker u_pcg_checker (.*);

`default_nettype wire

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pcg32 generator core: seeds, raw and ranged
// draws are pushed through the valid/ready input, each output beat is
// compared field by field against a cycle-free model of the generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int MAX_PRINTS     = 30;

  typedef struct {
    pcg_pkg::op_t       op;
    logic [31:0]        seed;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } draw_req_t;

  typedef struct {
    logic [31:0]        raw;
    logic signed [31:0] ranged;
    logic               full;
  } draw_res_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         func = 2'd0;
  logic [31:0]        seed = 32'd0;
  logic signed [31:0] range_low = 32'sd0;
  logic signed [31:0] range_high = 32'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [31:0]        raw_number;
  logic signed [31:0] ranged_number;
  logic               full_span;

  pcg32_random_generator_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .seed         (seed),
    .range_low    (range_low),
    .range_high   (range_high),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .raw_number   (raw_number),
    .ranged_number(ranged_number),
    .full_span    (full_span)
  );

  // model state of the generator
  logic [63:0] gen_state = 64'd0;
  logic [63:0] gen_inc   = 64'd1;

  draw_req_t pending_reqs[$];
  draw_res_t expected_draws[$];
  draw_req_t acc_req;
  draw_req_t next_req;
  draw_res_t want;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int results_seen   = 0;
  int op_count[4]    = '{0, 0, 0, 0};
  int quiet_cycles   = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    if (errors < MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [63:0] avalanche64(input logic [63:0] h);
    h = h ^ (h >> pcg_pkg::FMIX_SHIFT);
    h = h * pcg_pkg::FMIX_C1;
    h = h ^ (h >> pcg_pkg::FMIX_SHIFT);
    h = h * pcg_pkg::FMIX_C2;
    h = h ^ (h >> pcg_pkg::FMIX_SHIFT);
    return h;
  endfunction

  // step the lcg and return the permuted output of the old state
  function automatic logic [31:0] lcg_draw();
    logic [63:0] prev;
    logic [31:0] folded;
    int          rot;
    prev      = gen_state;
    gen_state = prev * pcg_pkg::LCG_MULT + gen_inc;
    folded    = 32'(((prev >> pcg_pkg::XS_SHIFT_A) ^ prev) >> pcg_pkg::XS_SHIFT_B);
    rot       = int'(prev >> pcg_pkg::ROT_SHIFT);
    if (rot == 0) return folded;
    return (folded >> rot) | (folded << (32 - rot));
  endfunction

  function automatic draw_res_t predict_draw(input draw_req_t r);
    draw_res_t   res;
    logic [63:0] mixed;
    logic [31:0] diff;
    logic [31:0] mag;
    logic [31:0] span;
    logic [31:0] dummy;
    res = '{raw: 32'd0, ranged: 32'sd0, full: 1'b0};
    case (r.op)
      pcg_pkg::OP_SEED: begin
        mixed     = avalanche64({31'd0, r.seed, 1'b1});
        gen_state = 64'd0;
        gen_inc   = {mixed[62:0], 1'b1};
        dummy     = lcg_draw();
        gen_state = gen_state + avalanche64(mixed);
        dummy     = lcg_draw();
      end
      pcg_pkg::OP_RAW: begin
        res.raw = lcg_draw();
      end
      pcg_pkg::OP_RANGE: begin
        diff    = r.hi - r.lo;
        mag     = diff[31] ? (32'd0 - diff) : diff;
        span    = mag + 32'd1;
        res.raw = lcg_draw();
        if (span == 32'd0) begin
          res.ranged = r.lo + res.raw;
          res.full   = 1'b1;
        end else begin
          res.ranged = r.lo + (res.raw % span);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic draw_req_t mk_req(input pcg_pkg::op_t op, input logic [31:0] s,
                                       input logic [31:0] lo, input logic [31:0] hi);
    draw_req_t r;
    r.op   = op;
    r.seed = s;
    r.lo   = lo;
    r.hi   = hi;
    return r;
  endfunction

  function automatic draw_req_t rand_req();
    draw_req_t r;
    int        pick;
    r.seed = $urandom;
    r.lo   = $urandom;
    r.hi   = $urandom;
    pick   = $urandom_range(99);
    if (pick < 8)       r.op = pcg_pkg::OP_SEED;
    else if (pick < 40) r.op = pcg_pkg::OP_RAW;
    else if (pick < 94) r.op = pcg_pkg::OP_RANGE;
    else                r.op = pcg_pkg::OP_NONE;
    case ($urandom_range(4))
      0: ;
      1: r.hi = r.lo + 32'($urandom_range(512)) - 32'd256;
      2: r.hi = r.lo + (32'd1 << $urandom_range(31)) - 32'($urandom_range(1));
      3: begin
        r.lo = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
        r.hi = $urandom_range(1) ? 32'h8000_0000 : $urandom;
      end
      default: r.hi = r.lo;
    endcase
    return r;
  endfunction

  // sender: holds payload until the beat is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        acc_req.op   = pcg_pkg::op_t'(func);
        acc_req.seed = seed;
        acc_req.lo   = range_low;
        acc_req.hi   = range_high;
        expected_draws.push_back(predict_draw(acc_req));
        op_count[func]++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_reqs.pop_front();
          in_valid   <= 1'b1;
          func       <= next_req.op;
          seed       <= next_req.seed;
          range_low  <= next_req.lo;
          range_high <= next_req.hi;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each output beat against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_draws.size() == 0) begin
          flag_error($sformatf("output beat with nothing expected raw=%h", raw_number));
        end else begin
          want = expected_draws.pop_front();
          if (raw_number !== want.raw)
            flag_error($sformatf("raw_number got %h exp %h", raw_number, want.raw));
          if (ranged_number !== want.ranged)
            flag_error($sformatf("ranged_number got %h exp %h", ranged_number,
                                 want.ranged));
          if (full_span !== want.full)
            flag_error($sformatf("full_span got %b exp %b", full_span, want.full));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
    @(negedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) pending_reqs.push_back(rand_req());
    while (pending_reqs.size() != 0) @(negedge clk);
  endtask

  initial begin
    // draws straight out of reset, before any seed
    pending_reqs.push_back(mk_req(pcg_pkg::OP_RAW, 32'd0, 32'd0, 32'd0));
    pending_reqs.push_back(mk_req(pcg_pkg::OP_RANGE, 32'hffff_ffff, 32'd0, 32'd9));
    pending_reqs.push_back(mk_req(pcg_pkg::OP_NONE, 32'hffff_ffff, 32'hffff_ffff,
                                  32'hffff_ffff));
    pending_reqs.push_back(mk_req(pcg_pkg::OP_SEED, 32'd0, 32'd0, 32'd0));
    pending_reqs.push_back(mk_req(pcg_pkg::OP_RAW, 32'd0, 32'd0, 32'd0));
    pending_reqs.push_back(mk_req(pcg_pkg::OP_SEED, 32'hffff_ffff, 32'hffff_ffff,
                                  32'h7fff_ffff));
    pending_reqs.push_back(mk_req(pcg_pkg::OP_RAW, 32'd0, 32'd0, 32'd0));
    // full-width and most-negative differences
    pending_reqs.push_back(mk_req(pcg_pkg::OP_RANGE, 32'd0, 32'h8000_0000, 32'h7fff_ffff));
    pending_reqs.push_back(mk_req(pcg_pkg::OP_RANGE, 32'd0, 32'h7fff_ffff, 32'h8000_0000));
    pending_reqs.push_back(mk_req(pcg_pkg::OP_RANGE, 32'd0, 32'd0, 32'h8000_0000));
    pending_reqs.push_back(mk_req(pcg_pkg::OP_RANGE, 32'd0, 32'h8000_0000, 32'd0));
    pending_reqs.push_back(mk_req(pcg_pkg::OP_RANGE, 32'd0, 32'd0, 32'h7fff_ffff));
    // single value and reversed ranges
    pending_reqs.push_back(mk_req(pcg_pkg::OP_RANGE, 32'd0, 32'd5, 32'd5));
    pending_reqs.push_back(mk_req(pcg_pkg::OP_RANGE, 32'd0, 32'h7fff_ffff, 32'h7fff_ffff));
    pending_reqs.push_back(mk_req(pcg_pkg::OP_RANGE, 32'd0, 32'd10, -32'sd10));
    pending_reqs.push_back(mk_req(pcg_pkg::OP_RANGE, 32'd0, -32'sd10, 32'd10));
    pending_reqs.push_back(mk_req(pcg_pkg::OP_RANGE, 32'd0, 32'd0, 32'hffff_ffff));
    pending_reqs.push_back(mk_req(pcg_pkg::OP_NONE, 32'h1234_5678, 32'd1, 32'd2));
    pending_reqs.push_back(mk_req(pcg_pkg::OP_SEED, 32'h8000_0000, 32'd0, 32'd0));
    pending_reqs.push_back(mk_req(pcg_pkg::OP_RANGE, 32'h5555_aaaa, 32'h8000_0000,
                                  32'h8000_0001));
    pending_reqs.push_back(mk_req(pcg_pkg::OP_RAW, 32'haaaa_5555, 32'hffff_ffff, 32'd0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    run_phase(0, 0, 200);
    run_phase(51, 0, 190);
    run_phase(0, 51, 190);
    run_phase(14, 14, 170);

    @(negedge clk);
    recv_stall_pct = 0;
    while (in_valid || expected_draws.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_draws.size() != 0)
      flag_error($sformatf("%0d expected beats never arrived", expected_draws.size()));

    $display("covered %0d seeds, %0d raw draws, %0d ranged draws, %0d unused codes",
             op_count[pcg_pkg::OP_SEED], op_count[pcg_pkg::OP_RAW],
             op_count[pcg_pkg::OP_RANGE], op_count[pcg_pkg::OP_NONE]);
    $display("%0d output beats checked under four handshake pressure mixes, %0d errors",
             results_seen, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
